// ===== rtl/core/slsort_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsort_pkg
// Shared widths, function and status codes, and the per-cell control bundle
// of the string sorter.
// ----------------------------------------------------------------------------
package slsort_pkg;

    localparam int CH_W     = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_PAST_END  = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
    } slsort_cell_ctl_t;

endpackage

// ===== rtl/core/slsort_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsort_req_if
// Request channel: function select, byte and end-of-word flag.
// ----------------------------------------------------------------------------
interface slsort_req_if;

    logic                             valid;
    logic                             ready;
    logic [slsort_pkg::FUNC_W-1:0]    func;
    logic [slsort_pkg::CH_W-1:0]      ch;
    logic                             word_end;

    modport source (output valid, output func, output ch, output word_end, input ready);
    modport sink   (input valid, input func, input ch, input word_end, output ready);

endinterface

// ===== rtl/core/slsort_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsort_rsp_if
// Response channel: sorted byte, word/list end marks and status.
// ----------------------------------------------------------------------------
interface slsort_rsp_if;

    logic                             valid;
    logic                             ready;
    logic [slsort_pkg::CH_W-1:0]      out_ch;
    logic                             out_word_end;
    logic                             out_list_end;
    logic [slsort_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output out_ch, output out_word_end, output out_list_end,
                    output status, input ready);
    modport sink   (input valid, input out_ch, input out_word_end, input out_list_end,
                    input status, output ready);

endinterface

// ===== rtl/core/slsort_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsort_cell
// One slot of the sorted word row. Compares its word against the entry and
// either holds, takes its left neighbor's word, or loads the entry.
// ----------------------------------------------------------------------------
module slsort_cell #(
    parameter int WORD_LEN = 16
) (
    input  logic                                        clk,
    input  slsort_pkg::slsort_cell_ctl_t                ctl,
    input  logic [WORD_LEN-1:0][slsort_pkg::CH_W-1:0]   entry_word,
    input  logic [$clog2(WORD_LEN+1)-1:0]               entry_len,
    input  logic [WORD_LEN-1:0][slsort_pkg::CH_W-1:0]   prev_word,
    input  logic [$clog2(WORD_LEN+1)-1:0]               prev_len,
    output logic [WORD_LEN-1:0][slsort_pkg::CH_W-1:0]   word,
    output logic [$clog2(WORD_LEN+1)-1:0]               len,
    output logic                                        after
);

    localparam int LL = $clog2(WORD_LEN+1);

    logic [WORD_LEN-1:0][slsort_pkg::CH_W-1:0] word_reg;
    logic [LL-1:0]                             len_reg;
    logic [LL-1:0]                             min_len;
    logic                                      hit;

    assign word = word_reg;
    assign len  = len_reg;
    assign min_len = (len_reg < entry_len) ? len_reg : entry_len;

    // first differing byte decides, else the longer word sorts after
    always_comb
    begin
        after = (len_reg > entry_len);
        hit   = 1'b0;
        for (int i = 0; i < WORD_LEN; i++)
        begin
            if (!hit && (LL'(i) < min_len) && (word_reg[i] != entry_word[i]))
            begin
                hit   = 1'b1;
                after = (word_reg[i] > entry_word[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            word_reg <= prev_word;
            len_reg  <= prev_len;
        end
        else if (ctl.load)
        begin
            word_reg <= entry_word;
            len_reg  <= entry_len;
        end
    end

endmodule

// ===== rtl/core/string_lexicographic_sorter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_lexicographic_sorter_top
// Keeps up to MAX_WORDS words of up to WORD_LEN bytes in ascending byte order
// in a row of cells, assembles words byte by byte, and reads them back.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. Reads,
// clears and appends that do not end a word are answered from the idle
// state. An append that ends a word and is stored latches the byte into the
// entry buffer, then in the insert state every cell compares its word
// against the entry in parallel and the row shifts right by one from the
// insertion point. One request is in flight at a time; a new request is
// taken while the previous response is being handed off. Store contents are
// not cleared at reset; only the control registers, such as the word count and cursors, are.
module string_lexicographic_sorter_top #(
    parameter int MAX_WORDS = 16,
    parameter int WORD_LEN  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    slsort_req_if.sink      req,
    slsort_rsp_if.source    rsp
);

    localparam int LL = $clog2(WORD_LEN+1);
    localparam int LP = $clog2(WORD_LEN);
    localparam int LC = $clog2(MAX_WORDS+1);
    localparam int LI = $clog2(MAX_WORDS);
    localparam int CW = slsort_pkg::CH_W;
    localparam int SW = slsort_pkg::STATUS_W;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_INSERT = 1'b1;

    logic                           state_reg, state_next;
    logic [LC-1:0]                  count_reg, count_next;
    logic [LL-1:0]                  entry_len_reg, entry_len_next;
    logic [WORD_LEN-1:0][CW-1:0]    entry_buf_reg;
    logic [LC-1:0]                  rd_word_reg, rd_word_next;
    logic [LP-1:0]                  rd_pos_reg, rd_pos_next;
    logic [SW-1:0]                  pend_status_reg, pend_status_next;
    logic                           out_valid_reg, out_valid_next;
    logic [CW-1:0]                  out_ch_reg, out_ch_next;
    logic                           out_word_end_reg, out_word_end_next;
    logic                           out_list_end_reg, out_list_end_next;
    logic [SW-1:0]                  out_status_reg, out_status_next;

    logic [MAX_WORDS-1:0][WORD_LEN-1:0][CW-1:0] cell_word;
    logic [MAX_WORDS-1:0][LL-1:0]               cell_len;
    logic [MAX_WORDS-1:0]                       cell_after;
    logic [MAX_WORDS-1:0]                       cell_gt;
    slsort_pkg::slsort_cell_ctl_t [MAX_WORDS-1:0] cell_ctl;

    logic            accept;
    logic            entry_full;
    logic            buf_write;
    logic [LI-1:0]   rd_idx;
    logic            rd_valid;
    logic [LL-1:0]   rd_len;
    logic            rd_last;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_ch       = out_ch_reg;
    assign rsp.out_word_end = out_word_end_reg;
    assign rsp.out_list_end = out_list_end_reg;
    assign rsp.status       = out_status_reg;

    assign entry_full = (entry_len_reg == LL'(WORD_LEN));
    assign rd_idx     = rd_word_reg[LI-1:0];
    assign rd_valid   = (rd_word_reg < count_reg);
    assign rd_len     = cell_len[rd_idx];
    assign rd_last    = ((LL'(rd_pos_reg) + LL'(1)) >= rd_len);

    // cell row
    for (genvar k = 0; k < MAX_WORDS; k++)
    begin : g_cell
        assign cell_gt[k] = (LC'(k) < count_reg) && cell_after[k];

        if (k == 0)
        begin : g_head
            assign cell_ctl[k].shift = 1'b0;
            assign cell_ctl[k].load  = (state_reg == ST_INSERT)
                                       && (cell_gt[k] || (count_reg == LC'(k)));
            slsort_cell #(.WORD_LEN(WORD_LEN)) u_cell (
                .clk        (clk),
                .ctl        (cell_ctl[k]),
                .entry_word (entry_buf_reg),
                .entry_len  (entry_len_reg),
                .prev_word  (entry_buf_reg),
                .prev_len   (entry_len_reg),
                .word       (cell_word[k]),
                .len        (cell_len[k]),
                .after      (cell_after[k])
            );
        end
        else
        begin : g_body
            assign cell_ctl[k].shift = (state_reg == ST_INSERT) && cell_gt[k-1];
            assign cell_ctl[k].load  = (state_reg == ST_INSERT) && !cell_gt[k-1]
                                       && (cell_gt[k] || (count_reg == LC'(k)));
            slsort_cell #(.WORD_LEN(WORD_LEN)) u_cell (
                .clk        (clk),
                .ctl        (cell_ctl[k]),
                .entry_word (entry_buf_reg),
                .entry_len  (entry_len_reg),
                .prev_word  (cell_word[k-1]),
                .prev_len   (cell_len[k-1]),
                .word       (cell_word[k]),
                .len        (cell_len[k]),
                .after      (cell_after[k])
            );
        end
    end

    assign buf_write = accept && (req.func == slsort_pkg::FUNC_APPEND) && !entry_full;

    always_ff @(posedge clk)
    begin
        if (buf_write)
        begin
            entry_buf_reg[entry_len_reg[LP-1:0]] <= req.ch;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        entry_len_next    = entry_len_reg;
        rd_word_next      = rd_word_reg;
        rd_pos_next       = rd_pos_reg;
        pend_status_next  = pend_status_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_ch_next       = out_ch_reg;
        out_word_end_next = out_word_end_reg;
        out_list_end_next = out_list_end_reg;
        out_status_next   = out_status_reg;

        if (state_reg == ST_INSERT)
        begin
            count_next        = count_reg + LC'(1);
            entry_len_next    = '0;
            rd_word_next      = '0;
            rd_pos_next       = '0;
            state_next        = ST_IDLE;
            out_valid_next    = 1'b1;
            out_ch_next       = '0;
            out_word_end_next = 1'b0;
            out_list_end_next = 1'b0;
            out_status_next   = pend_status_reg;
        end
        else if (accept)
        begin
            out_valid_next    = 1'b1;
            out_ch_next       = '0;
            out_word_end_next = 1'b0;
            out_list_end_next = 1'b0;
            out_status_next   = slsort_pkg::STATUS_OK;
            unique case (req.func)
                slsort_pkg::FUNC_APPEND:
                begin
                    if (!entry_full)
                    begin
                        entry_len_next = entry_len_reg + LL'(1);
                    end
                    pend_status_next = entry_full ? slsort_pkg::STATUS_TRUNCATED
                                                  : slsort_pkg::STATUS_OK;
                    out_status_next  = pend_status_next;
                    if (req.word_end)
                    begin
                        if (count_reg >= LC'(MAX_WORDS))
                        begin
                            entry_len_next  = '0;
                            out_status_next = slsort_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            // response goes out after the insert cycle
                            out_valid_next = 1'b0;
                            state_next     = ST_INSERT;
                        end
                    end
                end
                slsort_pkg::FUNC_READ:
                begin
                    if (!rd_valid)
                    begin
                        out_status_next = slsort_pkg::STATUS_PAST_END;
                    end
                    else
                    begin
                        out_ch_next = cell_word[rd_idx][rd_pos_reg];
                        if (rd_last)
                        begin
                            out_word_end_next = 1'b1;
                            out_list_end_next = ((rd_word_reg + LC'(1)) == count_reg);
                            rd_word_next      = rd_word_reg + LC'(1);
                            rd_pos_next       = '0;
                        end
                        else
                        begin
                            rd_pos_next = rd_pos_reg + LP'(1);
                        end
                    end
                end
                slsort_pkg::FUNC_CLEAR:
                begin
                    count_next     = '0;
                    entry_len_next = '0;
                    rd_word_next   = '0;
                    rd_pos_next    = '0;
                end
                slsort_pkg::FUNC_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            entry_len_reg   <= '0;
            rd_word_reg     <= '0;
            rd_pos_reg      <= '0;
            pend_status_reg <= slsort_pkg::STATUS_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            entry_len_reg   <= entry_len_next;
            rd_word_reg     <= rd_word_next;
            rd_pos_reg      <= rd_pos_next;
            pend_status_reg <= pend_status_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ch_reg       <= out_ch_next;
        out_word_end_reg <= out_word_end_next;
        out_list_end_reg <= out_list_end_next;
        out_status_reg   <= out_status_next;
    end

endmodule
